### hw/rtl/sic_pkg.sv
// ----------------------------------------------------------------------------
// Segment intersection classifier package
// Kind codes, sign codes and the kind lookup table for the classifier, and the
// kind and tolerance widths shared with its channel interfaces.
// ----------------------------------------------------------------------------
package sic_pkg;

    // Kind of intersection between segments AC and BD.
    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_CROSS  = 3'd1,
        KIND_BD_END = 3'd2,
        KIND_AC_END = 3'd3,
        KIND_SHARED = 3'd4,
        KIND_COINC  = 3'd5,
        KIND_COLLIN = 3'd6,
        KIND_IMPOSS = 3'd7
    } t_kind;

    localparam int KIND_W    = 3;
    localparam int TOL_W     = 6;
    localparam int SGN_W     = 2;
    localparam int KIDX_W    = 7;
    localparam int KIND_ROWS = 81;

    localparam logic [TOL_W-1:0] TOL_SHIFT_RESET = 6'd50;

    // Three-way sign codes of a doubled area.
    localparam logic [SGN_W-1:0] SGN_NEG  = 2'd0;
    localparam logic [SGN_W-1:0] SGN_ZERO = 2'd1;
    localparam logic [SGN_W-1:0] SGN_POS  = 2'd2;

    // Weights of the sign codes of A, C and B in the table index; D has weight 1.
    localparam logic [KIDX_W-1:0] WEIGHT_A = 7'd27;
    localparam logic [KIDX_W-1:0] WEIGHT_C = 7'd9;
    localparam logic [KIDX_W-1:0] WEIGHT_B = 7'd3;

    // Indexed by 27*sign(A) + 9*sign(C) + 3*sign(B) + sign(D).
    localparam t_kind KIND_TABLE [KIND_ROWS] = '{
        KIND_CROSS,  KIND_BD_END, KIND_NONE,   KIND_BD_END, KIND_IMPOSS,
        KIND_IMPOSS, KIND_NONE,   KIND_IMPOSS, KIND_IMPOSS,
        KIND_AC_END, KIND_SHARED, KIND_NONE,   KIND_SHARED, KIND_IMPOSS,
        KIND_IMPOSS, KIND_NONE,   KIND_IMPOSS, KIND_IMPOSS,
        KIND_NONE,   KIND_NONE,   KIND_NONE,   KIND_NONE,   KIND_COINC,
        KIND_NONE,   KIND_NONE,   KIND_NONE,   KIND_NONE,
        KIND_AC_END, KIND_SHARED, KIND_NONE,   KIND_SHARED, KIND_IMPOSS,
        KIND_IMPOSS, KIND_NONE,   KIND_IMPOSS, KIND_IMPOSS,
        KIND_IMPOSS, KIND_IMPOSS, KIND_COINC,  KIND_IMPOSS, KIND_COLLIN,
        KIND_IMPOSS, KIND_COINC,  KIND_IMPOSS, KIND_IMPOSS,
        KIND_IMPOSS, KIND_IMPOSS, KIND_NONE,   KIND_IMPOSS, KIND_IMPOSS,
        KIND_SHARED, KIND_NONE,   KIND_SHARED, KIND_AC_END,
        KIND_NONE,   KIND_NONE,   KIND_NONE,   KIND_NONE,   KIND_COINC,
        KIND_NONE,   KIND_NONE,   KIND_NONE,   KIND_NONE,
        KIND_IMPOSS, KIND_IMPOSS, KIND_NONE,   KIND_IMPOSS, KIND_IMPOSS,
        KIND_SHARED, KIND_NONE,   KIND_SHARED, KIND_AC_END,
        KIND_IMPOSS, KIND_IMPOSS, KIND_NONE,   KIND_IMPOSS, KIND_IMPOSS,
        KIND_BD_END, KIND_NONE,   KIND_BD_END, KIND_CROSS
    };

    function automatic logic [KIDX_W-1:0] kind_index(
        input logic [SGN_W-1:0] sa,
        input logic [SGN_W-1:0] sc,
        input logic [SGN_W-1:0] sb,
        input logic [SGN_W-1:0] sd
    );
        return KIDX_W'(KIDX_W'(sa) * WEIGHT_A) + KIDX_W'(KIDX_W'(sc) * WEIGHT_C)
             + KIDX_W'(KIDX_W'(sb) * WEIGHT_B) + KIDX_W'(sd);
    endfunction

endpackage

### hw/rtl/sic_ifs.sv
// ----------------------------------------------------------------------------
// Segment intersection classifier channels
// Valid/ready channels for point words, kind words and the tolerance write.
// ----------------------------------------------------------------------------
interface sic_in_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] c_x;
    logic signed [COORD_BITS-1:0] c_y;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] d_x;
    logic signed [COORD_BITS-1:0] d_y;

    modport source (output valid, a_x, a_y, c_x, c_y, b_x, b_y, d_x, d_y, input ready);
    modport sink   (input valid, a_x, a_y, c_x, c_y, b_x, b_y, d_x, d_y, output ready);
endinterface

interface sic_out_if;
    logic                         valid;
    logic                         ready;
    logic [sic_pkg::KIND_W-1:0]   kind;

    modport source (output valid, kind, input ready);
    modport sink   (input valid, kind, output ready);
endinterface

interface sic_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [sic_pkg::TOL_W-1:0]    tol_shift;

    modport source (output valid, tol_shift, input ready);
    modport sink   (input valid, tol_shift, output ready);
endinterface

### hw/rtl/segment_intersection_classifier.sv
// ----------------------------------------------------------------------------
// Segment intersection classifier
// Classifies how segments AC and BD meet from the signs of four exact doubled
// triangle areas, with a tolerance test that turns an impossible sign pattern
// into collinear.
//
//   Channel  Dir  Handshake     Word
//   i_in     in   valid/ready   a_x a_y c_x c_y b_x b_y d_x d_y
//   o_out    out  valid/ready   kind
//   i_cfg    in   valid/ready   tol_shift (ready always high)
//
// Six register stages: differences, products, areas, table lookup, largest
// area and limit, final compare. A word enters every cycle while o_out is
// not stalled; its kind is driven onto o_out from the final-compare stage.
// Reset clears all stage valid bits and loads tol_shift with 50.
// A stall on o_out holds the last stage; earlier stages keep filling bubbles,
// so i_in.ready drops only once every stage holds a word.
// ----------------------------------------------------------------------------
module segment_intersection_classifier #(
    parameter int COORD_BITS = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sic_in_if.sink     i_in,
    sic_out_if.source  o_out,
    sic_cfg_if.sink    i_cfg
);

    localparam int CW     = COORD_BITS;
    localparam int DW     = CW + 1;
    localparam int PW     = 2 * DW;
    localparam int AW     = PW + 1;
    localparam int SW     = 2 * CW;
    localparam int RW     = SW + 1;
    localparam int STAGES = 6;
    localparam int NPTS   = 4;
    localparam int NCRD   = 8;

    // Tolerance register.
    logic [sic_pkg::TOL_W-1:0] r_tol_shift;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol_shift <= sic_pkg::TOL_SHIFT_RESET;
        end else if (i_cfg.valid) begin
            r_tol_shift <= i_cfg.tol_shift;
        end
    end

    // Stage control: a stage loads when it is empty or the next one moves.
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic [STAGES-1:0] stage_en;

    always_comb begin
        stage_en[STAGES-1] = !r_vld[STAGES-1] || o_out.ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
        n_vld = r_vld;
        if (stage_en[0]) begin
            n_vld[0] = i_in.valid;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (stage_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_in.ready  = stage_en[0];
    assign o_out.valid = r_vld[STAGES-1];

    // Stage 1: coordinate differences and coordinate magnitudes.
    // Points are ordered A, B, C, D; area k uses points k+1, k+2, k+3.
    logic signed [CW-1:0] pt_x [NPTS];
    logic signed [CW-1:0] pt_y [NPTS];
    logic signed [CW-1:0] crd  [NCRD];

    logic signed [DW-1:0] r_qpx [NPTS];
    logic signed [DW-1:0] r_qpy [NPTS];
    logic signed [DW-1:0] r_rpx [NPTS];
    logic signed [DW-1:0] r_rpy [NPTS];
    logic [CW-1:0]        r_cmag [NCRD];

    always_comb begin
        pt_x[0] = i_in.a_x;  pt_y[0] = i_in.a_y;
        pt_x[1] = i_in.b_x;  pt_y[1] = i_in.b_y;
        pt_x[2] = i_in.c_x;  pt_y[2] = i_in.c_y;
        pt_x[3] = i_in.d_x;  pt_y[3] = i_in.d_y;
        for (int k = 0; k < NPTS; k++) begin
            crd[2*k]   = pt_x[k];
            crd[2*k+1] = pt_y[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            for (int k = 0; k < NPTS; k++) begin
                r_qpx[k] <= DW'(pt_x[2'(k + 2)]) - DW'(pt_x[2'(k + 1)]);
                r_qpy[k] <= DW'(pt_y[2'(k + 2)]) - DW'(pt_y[2'(k + 1)]);
                r_rpx[k] <= DW'(pt_x[2'(k + 3)]) - DW'(pt_x[2'(k + 1)]);
                r_rpy[k] <= DW'(pt_y[2'(k + 3)]) - DW'(pt_y[2'(k + 1)]);
            end
            for (int j = 0; j < NCRD; j++) begin
                r_cmag[j] <= crd[j][CW-1] ? $unsigned(-crd[j]) : $unsigned(crd[j]);
            end
        end
    end

    // Stage 2: cross products and largest coordinate magnitude.
    logic signed [PW-1:0] r_prod0 [NPTS];
    logic signed [PW-1:0] r_prod1 [NPTS];
    logic [CW-1:0]        r_maxc;
    logic [CW-1:0]        maxc;

    always_comb begin
        maxc = r_cmag[0];
        for (int j = 1; j < NCRD; j++) begin
            if (r_cmag[j] > maxc) begin
                maxc = r_cmag[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            for (int k = 0; k < NPTS; k++) begin
                r_prod0[k] <= PW'(r_qpx[k]) * PW'(r_rpy[k]);
                r_prod1[k] <= PW'(r_rpx[k]) * PW'(r_qpy[k]);
            end
            r_maxc <= maxc;
        end
    end

    // Stage 3: doubled areas and the squared largest coordinate.
    logic signed [AW-1:0] r_area [NPTS];
    logic [SW-1:0]        r_sq;

    always_ff @(posedge i_clk) begin
        if (stage_en[2]) begin
            for (int k = 0; k < NPTS; k++) begin
                r_area[k] <= AW'(r_prod0[k]) - AW'(r_prod1[k]);
            end
            r_sq <= SW'(r_maxc) * SW'(r_maxc);
        end
    end

    // Stage 4: sign pattern lookup and area magnitudes.
    logic [sic_pkg::SGN_W-1:0]  sgn [NPTS];
    logic [sic_pkg::KIDX_W-1:0] kidx;
    sic_pkg::t_kind             r_kind4;
    logic [AW-1:0]              r_amag [NPTS];
    logic [RW-1:0]              r_rhs;

    always_comb begin
        for (int k = 0; k < NPTS; k++) begin
            if (r_area[k] < 0) begin
                sgn[k] = sic_pkg::SGN_NEG;
            end else if (r_area[k] == '0) begin
                sgn[k] = sic_pkg::SGN_ZERO;
            end else begin
                sgn[k] = sic_pkg::SGN_POS;
            end
        end
        kidx = sic_pkg::kind_index(sgn[0], sgn[2], sgn[1], sgn[3]);
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[3]) begin
            r_kind4 <= sic_pkg::KIND_TABLE[kidx];
            for (int k = 0; k < NPTS; k++) begin
                r_amag[k] <= r_area[k][AW-1] ? $unsigned(-r_area[k])
                                             : $unsigned(r_area[k]);
            end
            r_rhs <= {r_sq, 1'b0};
        end
    end

    // Stage 5: largest area and the limit ceil(rhs / 2^tol_shift).
    logic [AW-1:0]  maxa;
    logic [RW-1:0]  lim_mask;
    logic           lim_rem;
    logic [RW-1:0]  lim;
    logic [AW-1:0]  r_maxarea;
    logic [RW-1:0]  r_lim;
    sic_pkg::t_kind r_kind5;

    always_comb begin
        maxa = r_amag[0];
        for (int k = 1; k < NPTS; k++) begin
            if (r_amag[k] > maxa) begin
                maxa = r_amag[k];
            end
        end
        lim_mask = ~({RW{1'b1}} << r_tol_shift);
        lim_rem  = |(r_rhs & lim_mask);
        lim      = (r_rhs >> r_tol_shift) + RW'(lim_rem);
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[4]) begin
            r_maxarea <= maxa;
            r_lim     <= lim;
            r_kind5   <= r_kind4;
        end
    end

    // Stage 6: tolerance override and output register.
    sic_pkg::t_kind r_kind6;

    always_ff @(posedge i_clk) begin
        if (stage_en[5]) begin
            if (r_kind5 == sic_pkg::KIND_IMPOSS && r_maxarea < AW'(r_lim)) begin
                r_kind6 <= sic_pkg::KIND_COLLIN;
            end else begin
                r_kind6 <= r_kind5;
            end
        end
    end

    assign o_out.kind = r_kind6;

`ifndef SYNTHESIS
    // Input back-pressure only once the whole pipeline is full and stalled.
    a_ready_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (&r_vld) && !o_out.ready)
        else $error("input stalled while the pipeline has a bubble");

    // A word waiting behind a stalled output stays in place.
    a_hold_stage : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[STAGES-1] && !o_out.ready && r_vld[STAGES-2]) |=> r_vld[STAGES-2])
        else $error("word lost behind a stalled output");

    // Four zero areas always classify as collinear.
    a_zero_collin : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && stage_en[3] && r_area[0] == '0 && r_area[1] == '0
         && r_area[2] == '0 && r_area[3] == '0) |=> r_kind4 == sic_pkg::KIND_COLLIN)
        else $error("all-zero areas not classified as collinear");
`endif

endmodule
